// File: src/pda_pkg.sv
// Package for the Poisson deviance accumulator: widths, constants, the request record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pda_pkg;
    localparam int          FRAC_BITS_DEF = 16;
    localparam logic [31:0] SCALE_RESET   = 32'd65536;
    localparam logic [31:0] LN2_Q32       = 32'd2977044472;
    localparam logic [63:0] SMAX          = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          QDEPTH        = 4;

    typedef struct packed {
        logic [31:0] response;
        logic [31:0] mean;
        logic [31:0] weight;
        logic        last;
    } obs_t;
endpackage
`default_nettype wire

// File: src/poisson_deviance_accumulator_unit.sv
// Top level of the Poisson deviance accumulator.
// Depends on pda_pkg, pda_front, pda_back.
//
//  channel   | handshake            | payload
//  input     | in_valid/in_ready    | response, fitted_mean, weight, last
//  output    | out_valid/out_ready  | deviance, saturated
//  config    | cfg_valid/cfg_ready  | cfg_data (scale)
//
// For a request with nonzero response the back end runs two log2 loops on one squarer,
// three two-pass multiplies on one 32x32 multiplier, plus pop, setup and accumulate
// steps; a zero response skips the log2 loops and two of the multiplies.
// A last request adds setup, 81 bit-serial division steps, sign and clamp (a zero
// sum or zero scale skips the division steps), then the result is held until
// out_ready. A 4-deep request queue lets the front accept while the back works;
// a full queue drops in_ready. Asynchronous active-low reset clears control,
// the sum and the overflow flag; scale resets to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module poisson_deviance_accumulator_unit
    import pda_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire  [31:0] response,
    input  wire  [31:0] fitted_mean,
    input  wire  [31:0] weight,
    input  wire         last,
    input  wire         in_valid,
    output logic        in_ready,
    output logic [63:0] deviance,
    output logic        saturated,
    output logic        out_valid,
    input  wire         out_ready,
    input  wire  [31:0] cfg_data,
    input  wire         cfg_valid,
    output logic        cfg_ready
);
    logic [31:0] scale_reg;
    logic        q_valid, q_pop;
    obs_t        q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_valid)
            scale_reg <= cfg_data;
    end

    pda_front u_front (
        .clk, .rst_n, .response, .fitted_mean, .weight, .last,
        .in_valid, .in_ready, .q_valid, .q_data, .q_pop
    );

    pda_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .scale(scale_reg), .q_valid, .q_data, .q_pop,
        .out_valid, .out_ready, .deviance, .saturated
    );
endmodule
`default_nettype wire

// File: src/pda_front.sv
// Front end: accepts observation requests, replaces a zero mean by one LSB,
// and queues them for the back end. Depends on pda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pda_front
    import pda_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire  [31:0] response,
    input  wire  [31:0] fitted_mean,
    input  wire  [31:0] weight,
    input  wire         last,
    input  wire         in_valid,
    output logic        in_ready,
    output logic        q_valid,
    output obs_t        q_data,
    input  wire         q_pop
);
    localparam int AW = $clog2(QDEPTH);
    obs_t          mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push;
    obs_t          item;

    assign in_ready = (cnt_reg != (AW+1)'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rp_reg];

    always_comb
    begin
        item.response = response;
        item.mean     = (fitted_mean == 32'd0) ? 32'd1 : fitted_mean;
        item.weight   = weight;
        item.last     = last;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

// File: src/pda_back.sv
// Back end: sequencer for log2, products, accumulate and final division.
// One shared 32x32 multiplier, one step per cycle except while idle or waiting for out_ready. Depends on pda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pda_back
    import pda_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire  [31:0] scale,
    input  wire         q_valid,
    input  obs_t        q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [63:0] deviance,
    output logic        saturated
);
    localparam int SH = 32 - FRAC_BITS;
    localparam int DS = FRAC_BITS + 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_LOGR = 4'd1, S_LOGM = 4'd2,
        S_LN   = 4'd3, S_RLN  = 4'd4, S_INNER = 4'd5, S_TERM = 4'd6,
        S_ACC  = 4'd7, S_DIV  = 4'd8, S_OUT = 4'd9, S_MUL = 4'd10;

    logic [3:0]   state_reg, state_next, ret_reg;
    obs_t         it_reg;
    logic [5:0]   cnt_reg;
    logic [31:0]  y_reg;
    logic [31:0]  frac_reg;
    logic signed [64:0] lr_reg;
    logic signed [64:0] d_reg;
    logic [63:0]  a_reg;
    logic [31:0]  b_reg;
    logic [1:0]   part_reg;
    logic [127:0] prod_reg;
    logic signed [65:0] inner_reg;
    logic signed [63:0] sum_reg;
    logic         ovf_reg;
    logic         sat_reg;
    logic         qovf_reg;
    logic [31:0]  rem_reg;
    logic [63:0]  quo_reg;
    logic [6:0]   dcnt_reg;
    logic [63:0]  dmag;

    // Position of the top set bit; the mantissa is normalized in the log2 setup step.
    function automatic logic [4:0] topbit(input logic [31:0] x);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    logic [4:0]  p_cur;
    logic [31:0] x_cur;
    logic [63:0] sq;
    logic [33:0] ysq;
    logic [63:0] pp;

    assign x_cur = (state_reg == S_LOGR) ? it_reg.response : it_reg.mean;
    assign p_cur = topbit(x_cur);
    assign sq    = 64'(y_reg) * 64'(y_reg);
    assign ysq   = sq[63:30];
    assign pp    = 64'(part_reg[0] ? a_reg[63:32] : a_reg[31:0]) * 64'(b_reg);
    assign dmag  = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = (state_reg == S_OUT);
    assign deviance  = quo_reg;
    assign saturated = sat_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) state_next = (q_data.response != 0) ? S_LOGR : S_INNER;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = state_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            it_reg    <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
            y_reg     <= '0;
            frac_reg  <= '0;
            lr_reg    <= '0;
            d_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            part_reg  <= '0;
            prod_reg  <= '0;
            inner_reg <= '0;
            sat_reg   <= 1'b0;
            qovf_reg  <= 1'b0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        it_reg    <= q_data;
                        cnt_reg   <= '0;
                        lr_reg    <= '0;
                        inner_reg <= 66'(signed'({34'd0, q_data.mean}) <<< SH);
                        state_reg <= state_next;
                    end
                end
                S_LOGR, S_LOGM:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        y_reg    <= (p_cur == 5'd31) ? (x_cur >> 1)
                                                     : (x_cur << (5'd30 - p_cur));
                        frac_reg <= '0;
                        d_reg    <= 65'(signed'({1'b0, p_cur})) - 65'(FRAC_BITS);
                        cnt_reg  <= 6'd1;
                    end
                    else if (cnt_reg <= 6'd32)
                    begin
                        frac_reg <= {frac_reg[30:0], ysq[31]};
                        y_reg    <= ysq[31] ? ysq[32:1] : ysq[31:0];
                        cnt_reg  <= cnt_reg + 6'd1;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        if (state_reg == S_LOGR)
                        begin
                            lr_reg    <= (d_reg <<< 32) + 65'(frac_reg);
                            state_reg <= S_LOGM;
                        end
                        else
                        begin
                            d_reg    <= lr_reg - ((d_reg <<< 32) + 65'(frac_reg));
                            state_reg <= S_LN;
                        end
                    end
                end
                S_LN:
                begin
                    a_reg    <= d_reg[64] ? 64'(-d_reg) : d_reg[63:0];
                    b_reg    <= LN2_Q32;
                    part_reg <= '0;
                    prod_reg <= '0;
                    ret_reg  <= S_RLN;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg <= prod_reg + (128'(pp) << (part_reg[0] ? 32 : 0));
                    part_reg <= part_reg + 2'd1;
                    if (part_reg[0]) state_reg <= ret_reg;
                end
                S_RLN:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        // ln magnitude = prod >> 32, clamp
                        if (prod_reg[127:95] != 0)
                        begin
                            ovf_reg   <= 1'b1;
                            a_reg     <= SMAX;
                        end
                        else
                        begin
                            a_reg     <= prod_reg[95:32];
                        end
                        b_reg    <= it_reg.response;
                        part_reg <= '0;
                        prod_reg <= '0;
                        ret_reg  <= S_RLN;
                        cnt_reg  <= 6'd1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        logic [63:0] rl;
                        rl = SMAX;
                        if (prod_reg[127:63+FRAC_BITS] != 0)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            rl = prod_reg[63+FRAC_BITS:FRAC_BITS];
                        end
                        inner_reg <= inner_reg
                            + (d_reg[64] ? -66'(signed'({2'b0, rl}))
                                         :  66'(signed'({2'b0, rl})))
                            - (66'(signed'({34'd0, it_reg.response})) <<< SH);
                        cnt_reg   <= '0;
                        state_reg <= S_INNER;
                    end
                end
                S_INNER:
                begin
                    a_reg    <= inner_reg[65] ? 64'(-inner_reg) : inner_reg[63:0];
                    b_reg    <= it_reg.weight;
                    part_reg <= '0;
                    prod_reg <= '0;
                    ret_reg  <= S_TERM;
                    state_reg <= S_MUL;
                end
                S_TERM:
                begin
                    logic [63:0] t;
                    logic signed [64:0] s;
                    logic v;
                    v = prod_reg[127:63+FRAC_BITS] != 0;
                    t = v ? SMAX : prod_reg[63+FRAC_BITS:FRAC_BITS];
                    s = inner_reg[65] ? 65'(sum_reg) - 65'(t) : 65'(sum_reg) + 65'(t);
                    if (s > 65'(signed'({1'b0, SMAX})))
                    begin
                        sum_reg <= signed'(SMAX); v = 1'b1;
                    end
                    else if (s < -65'(signed'({1'b0, SMAX})))
                    begin
                        sum_reg <= -signed'(SMAX); v = 1'b1;
                    end
                    else
                    begin
                        sum_reg <= s[63:0];
                    end
                    if (v) ovf_reg <= 1'b1;
                    state_reg <= it_reg.last ? S_ACC : S_IDLE;
                end
                S_ACC:
                begin
                    // numerator dmag << DS, restoring division, one bit per cycle
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    dcnt_reg <= '0;
                    qovf_reg <= 1'b0;
                    sat_reg  <= ovf_reg;
                    a_reg    <= dmag;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (dmag == 0)
                    begin
                        quo_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (scale == 0)
                    begin
                        sat_reg   <= 1'b1;
                        quo_reg   <= sum_reg[63] ? 64'(-signed'(SMAX)) : SMAX;
                        state_reg <= S_OUT;
                    end
                    else if (dcnt_reg != 7'(64 + DS))
                    begin
                        logic [32:0] r2;
                        r2 = {rem_reg, a_reg[63]};
                        if (r2 >= {1'b0, scale})
                        begin
                            rem_reg <= 32'(r2 - {1'b0, scale});
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= r2[31:0];
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        // a bit pushed past bit 63 means the quotient is over the clamp
                        if (quo_reg[63]) qovf_reg <= 1'b1;
                        a_reg    <= {a_reg[62:0], 1'b0};
                        dcnt_reg <= dcnt_reg + 7'd1;
                    end
                    else
                    begin
                        logic [63:0] q;
                        q = quo_reg;
                        if (qovf_reg || q[63])
                        begin
                            q = SMAX; sat_reg <= 1'b1;
                        end
                        quo_reg   <= sum_reg[63] ? 64'(-q) : q;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        sum_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/pda_checker.sv
// Port-level checker for the deviance accumulator, bound to the top level.
// Depends on poisson_deviance_accumulator_unit ports only.
`timescale 1ns / 1ps
`default_nettype none
module pda_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [63:0] deviance,
    input wire        saturated
);
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input request dropped");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(deviance) && $stable(saturated))
        else $error("output request dropped");
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> deviance != 64'h8000_0000_0000_0000)
        else $error("deviance hit negative limit");
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("back-to-back result");
endmodule

bind poisson_deviance_accumulator_unit pda_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .deviance, .saturated
);
`default_nettype wire
